FILE: src/mts_pkg.sv
// Shared types and codes for the max-tracking stack.
`default_nettype none
package mts_pkg;

	localparam int WORD_W  = 32;
	localparam int FILL_W  = 7;
	localparam int OPC_W   = 2;
	localparam int STAT_W  = 2;

	localparam logic [OPC_W-1:0] OP_PUSH = 2'd0;
	localparam logic [OPC_W-1:0] OP_POP  = 2'd1;
	localparam logic [OPC_W-1:0] OP_MAX  = 2'd2;
	localparam logic [OPC_W-1:0] OP_TOP  = 2'd3;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [OPC_W-1:0]         opcode;
		logic signed [WORD_W-1:0] push_value;
	} cmd_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] result_value;
		logic [STAT_W-1:0]        status;
		logic [FILL_W-1:0]        fill_count;
	} res_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] run_max;
		logic signed [WORD_W-1:0] value;
	} entry_t;

endpackage
`default_nettype wire

FILE: src/max_tracking_stack_core.sv
// Max-tracking stack: top level with control and entry memory.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+--------------
//  command | cmd_valid | cmd_stall | cmd (cmd_t)
//  result  | res_valid | res_stall | res (res_t)
//
//  A new command waits until the last result is registered: the read of the
//  top entry is registered on the transfer, then the execute step registers
//  the result. Reset clears fill count, state and res_valid; not entries.
//  cmd_stall is high from a command transfer until its result is registered.
//  res_stall holds the execute step, and thus the stack, until res is free.
`default_nettype none
module max_tracking_stack_core
	import mts_pkg::*;
#(
	parameter int STACK_DEPTH = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_valid,
	output logic      cmd_stall,
	input  wire cmd_t cmd,
	output logic      res_valid,
	input  wire logic res_stall,
	output res_t      res
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int EW = $bits(entry_t);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   count_q;
	cmd_t            cmd_q;
	logic            res_valid_q;
	res_t            res_q;

	logic            accept;
	logic            done;
	logic            we;
	logic [AW-1:0]   waddr;
	entry_t          wentry;
	logic [AW-1:0]   raddr;
	logic [EW-1:0]   rdata;
	entry_t          top;
	logic [CW-1:0]   count_n;
	logic [WORD_W-1:0] result_n;
	logic [STAT_W-1:0] status_n;
	logic            empty;
	logic            full;

	assign accept    = cmd_valid && !cmd_stall;
	assign cmd_stall = (state_q != S_IDLE);
	assign done      = (state_q == S_EXEC) && (!res_valid_q || !res_stall);
	assign empty     = (count_q == '0);
	assign full      = (count_q == CW'(STACK_DEPTH));
	assign raddr     = AW'(count_q - CW'(1));
	assign waddr     = AW'(count_q);
	assign top       = entry_t'(rdata);

	mts_ram #(
		.WIDTH(EW),
		.DEPTH(STACK_DEPTH)
	) u_entry_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wentry),
		.re   (accept),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_comb begin
		we       = 1'b0;
		wentry   = '{run_max: cmd_q.push_value, value: cmd_q.push_value};
		count_n  = count_q;
		result_n = '0;
		status_n = ST_OK;
		case (cmd_q.opcode)
			OP_PUSH: begin
				if (full) begin
					status_n = ST_FULL;
				end else begin
					we      = done;
					count_n = count_q + CW'(1);
					if (!empty && (top.run_max > cmd_q.push_value)) begin
						wentry.run_max = top.run_max;
					end
				end
			end
			OP_POP: begin
				if (empty) begin
					status_n = ST_EMPTY;
				end else begin
					result_n = top.value;
					count_n  = count_q - CW'(1);
				end
			end
			OP_MAX: begin
				if (empty) begin
					status_n = ST_EMPTY;
				end else begin
					result_n = top.run_max;
				end
			end
			OP_TOP: begin
				if (empty) begin
					status_n = ST_EMPTY;
				end else begin
					result_n = top.value;
				end
			end
			default: begin
				status_n = ST_EMPTY;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (done) begin
						state_q <= S_IDLE;
						count_q <= count_n;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			res_valid_q <= done || (res_valid_q && res_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
		end
		if (done) begin
			res_q.result_value <= result_n;
			res_q.status       <= status_n;
			res_q.fill_count   <= FILL_W'(count_n);
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(STACK_DEPTH))
		else $error("fill count above depth");

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(we && accept))
		else $error("memory read and write in the same cycle");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(we) |=> (count_q == $past(count_q) + CW'(1)))
		else $error("push did not advance the fill count");

	a_full_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.status == ST_FULL) |-> full)
		else $error("full status with room left");

	a_exec_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_EXEC) && !res_valid_q || (state_q == S_EXEC))
		else $error("command transfer not followed by execute");

endmodule
`default_nettype wire

FILE: src/mts_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none
module mts_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]              rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

FILE: dv/tb_max_tracking_stack_core.sv
// Testbench for max_tracking_stack_core: directed table and random op walks, scoreboarded.
`timescale 1ns / 1ps
`default_nettype none
module tb_max_tracking_stack_core;
	import mts_pkg::*;

	localparam int STACK_DEPTH = 64;
	localparam int RAND_ITEMS  = 1200;
	localparam int STALL_LIMIT = 5000;

	typedef struct {
		cmd_t c;
		bit   typed;
		res_t want;
	} dir_row_t;

	typedef enum {CLIMB, DRAIN, CHURN} walk_mode_e;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic cmd_valid = 1'b0;
	cmd_t cmd       = '0;
	logic res_stall = 1'b0;
	logic cmd_stall;
	logic res_valid;
	res_t res;

	logic signed [WORD_W-1:0] value_mem   [STACK_DEPTH];
	logic signed [WORD_W-1:0] run_max_mem [STACK_DEPTH];
	int   model_fill = 0;
	res_t due_res_q [$];

	int send_idle_pct  = 16;
	int recv_stall_pct = 85;
	int error_count    = 0;
	int ops_sent       = 0;
	int pushes_done    = 0;
	int full_refusals  = 0;
	int empty_flags    = 0;
	int results_seen   = 0;
	int quiet_cycles   = 0;

	dir_row_t dir_rows [23] = '{
		'{'{OP_POP,  32'sh0000_0000}, 1'b1, '{32'sh0, ST_EMPTY, 7'd0}},
		'{'{OP_MAX,  32'sh0000_0000}, 1'b1, '{32'sh0, ST_EMPTY, 7'd0}},
		'{'{OP_TOP,  32'shFFFF_FFFF}, 1'b1, '{32'sh0, ST_EMPTY, 7'd0}},
		'{'{OP_PUSH, 32'sh8000_0000}, 1'b1, '{32'sh0, ST_OK, 7'd1}},
		'{'{OP_MAX,  32'sh0000_0000}, 1'b1, '{32'sh8000_0000, ST_OK, 7'd1}},
		'{'{OP_TOP,  32'sh0000_0000}, 1'b1, '{32'sh8000_0000, ST_OK, 7'd1}},
		'{'{OP_PUSH, 32'sh7FFF_FFFF}, 1'b1, '{32'sh0, ST_OK, 7'd2}},
		'{'{OP_MAX,  32'sh0000_0000}, 1'b1, '{32'sh7FFF_FFFF, ST_OK, 7'd2}},
		'{'{OP_PUSH, 32'shFFFF_FFFF}, 1'b0, '0},
		'{'{OP_MAX,  32'sh0000_0000}, 1'b0, '0},
		'{'{OP_TOP,  32'sh0000_0000}, 1'b0, '0},
		'{'{OP_POP,  32'sh0000_0000}, 1'b0, '0},
		'{'{OP_POP,  32'sh0000_0000}, 1'b0, '0},
		'{'{OP_MAX,  32'sh0000_0000}, 1'b0, '0},
		'{'{OP_POP,  32'sh0000_0000}, 1'b0, '0},
		'{'{OP_POP,  32'shFFFF_FFFF}, 1'b1, '{32'sh0, ST_EMPTY, 7'd0}},
		'{'{OP_PUSH, 32'sh0000_0000}, 1'b1, '{32'sh0, ST_OK, 7'd1}},
		'{'{OP_PUSH, 32'sh5555_5555}, 1'b0, '0},
		'{'{OP_PUSH, 32'shAAAA_AAAA}, 1'b0, '0},
		'{'{OP_MAX,  32'sh0000_0000}, 1'b0, '0},
		'{'{OP_TOP,  32'shFFFF_FFFF}, 1'b0, '0},
		'{'{OP_POP,  32'sh0000_0000}, 1'b0, '0},
		'{'{OP_POP,  32'sh0000_0000}, 1'b0, '0}
	};

	max_tracking_stack_core #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd      (cmd),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic res_t predict_stack_op(input cmd_t c);
		res_t r;
		r = '0;
		r.status = ST_OK;
		if (c.opcode == OP_PUSH) begin
			if (model_fill >= STACK_DEPTH) begin
				r.status = ST_FULL;
				full_refusals++;
			end else begin
				value_mem[model_fill] = c.push_value;
				if (model_fill == 0 || c.push_value > run_max_mem[model_fill-1])
					run_max_mem[model_fill] = c.push_value;
				else
					run_max_mem[model_fill] = run_max_mem[model_fill-1];
				model_fill++;
				pushes_done++;
			end
		end else if (model_fill == 0) begin
			r.status = ST_EMPTY;
			empty_flags++;
		end else if (c.opcode == OP_POP) begin
			model_fill--;
			r.result_value = value_mem[model_fill];
		end else if (c.opcode == OP_MAX) begin
			r.result_value = run_max_mem[model_fill-1];
		end else begin
			r.result_value = value_mem[model_fill-1];
		end
		r.fill_count = model_fill[FILL_W-1:0];
		return r;
	endfunction

	task automatic note_mismatch(input string msg);
		$display("%0t MISMATCH %s", $time, msg);
		error_count++;
	endtask

	task automatic send_cmd(input cmd_t c, input bit typed, input res_t want);
		res_t pred;
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= c;
		do @(posedge clk); while (cmd_stall);
		pred = predict_stack_op(c);
		due_res_q.push_back(typed ? want : pred);
		ops_sent++;
	endtask

	always @(posedge clk)
		res_stall <= ($urandom_range(99) < recv_stall_pct);

	always @(posedge clk) begin
		res_t exp_r;
		if (arst_n && res_valid && !res_stall) begin
			results_seen++;
			if (due_res_q.size() == 0) begin
				note_mismatch($sformatf("unexpected result %p", res));
			end else begin
				exp_r = due_res_q.pop_front();
				if (res.result_value !== exp_r.result_value)
					note_mismatch($sformatf("result_value got %h want %h",
						res.result_value, exp_r.result_value));
				if (res.status !== exp_r.status)
					note_mismatch($sformatf("status got %0d want %0d",
						res.status, exp_r.status));
				if (res.fill_count !== exp_r.fill_count)
					note_mismatch($sformatf("fill_count got %0d want %0d",
						res.fill_count, exp_r.fill_count));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (cmd_valid && !cmd_stall) || (res_valid && !res_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles, %0d results outstanding",
				STALL_LIMIT, due_res_q.size());
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int         i;
		int         roll;
		walk_mode_e mode;
		cmd_t       c;
		mode = CLIMB;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[k])
			send_cmd(dir_rows[k].c, dir_rows[k].typed, dir_rows[k].want);

		for (i = 0; i < RAND_ITEMS; i++) begin
			if (i == RAND_ITEMS / 3) begin
				send_idle_pct  = 85;
				recv_stall_pct = 16;
			end else if (i == 2 * RAND_ITEMS / 3) begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end
			if (model_fill == STACK_DEPTH && $urandom_range(3) == 0)
				mode = DRAIN;
			else if (model_fill == 0 && $urandom_range(2) == 0)
				mode = ($urandom_range(1) == 0) ? CLIMB : CHURN;
			else if (mode == CHURN && $urandom_range(49) == 0)
				mode = CLIMB;

			roll = $urandom_range(99);
			case (mode)
				CLIMB: c.opcode = (roll < 75) ? OP_PUSH : (roll < 85) ? OP_POP :
					(roll < 93) ? OP_MAX : OP_TOP;
				DRAIN: c.opcode = (roll < 75) ? OP_POP : (roll < 85) ? OP_PUSH :
					(roll < 93) ? OP_MAX : OP_TOP;
				default: c.opcode = OPC_W'($urandom_range(3));
			endcase

			case ($urandom_range(7))
				0: c.push_value = 32'sh8000_0000;
				1: c.push_value = 32'sh7FFF_FFFF;
				2: c.push_value = 32'sh0;
				3: c.push_value = -32'sd1;
				4: c.push_value = WORD_W'($urandom_range(31)) - 32'sd16;
				default: c.push_value = $urandom();
			endcase
			send_cmd(c, 1'b0, '0);
		end

		cmd_valid <= 1'b0;
		while (due_res_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("covered %0d operations (%0d pushes stored, %0d refused on full, %0d flagged empty)",
			ops_sent, pushes_done, full_refusals, empty_flags);
		$display("checked %0d results under three sender/receiver throttle mixes",
			results_seen);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
`default_nettype wire

FILE: files.f
src/mts_pkg.sv
src/mts_ram.sv
src/max_tracking_stack_core.sv
dv/tb_max_tracking_stack_core.sv
